>>> design/sfpc_pkg.sv
// Shared types, constants and codes of the split-flap position controller.
package sfpc_pkg;

   localparam int SAMPLE_W       = 12;
   localparam int TARGET_W       = 6;
   localparam int POS_OUT_W      = 6;
   localparam int CSR_ADDR_W     = 4;
   localparam int CSR_DATA_W     = 32;
   localparam int REQ_DATA_W     = 32;
   localparam int RSP_DATA_W     = 16;
   localparam int FLAP_COUNT_DEF = 64;

   localparam logic [SAMPLE_W-1:0] DEFAULT_FALL = SAMPLE_W'(500);
   localparam logic [SAMPLE_W-1:0] DEFAULT_RISE = SAMPLE_W'(1500);

   typedef enum logic [1:0] {
      REG_FLAP_FALL = 2'd0,
      REG_FLAP_RISE = 2'd1,
      REG_HOME_FALL = 2'd2,
      REG_HOME_RISE = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      CHECK_NONE     = 2'd0,
      CHECK_AGREE    = 2'd1,
      CHECK_DISAGREE = 2'd2
   } check_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] fall;
      logic [SAMPLE_W-1:0] rise;
   } hyst_thr_type;

   typedef struct packed {
      hyst_thr_type flap;
      hyst_thr_type home;
   } cfg_type;

endpackage

>>> design/sfpc_csr.sv
// Threshold register file behind the APB-style configuration port.
module sfpc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sfpc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [sfpc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [sfpc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output sfpc_pkg::cfg_type                cfg
);
   import sfpc_pkg::*;

   cfg_type             cfg_ff;
   cfg_type             cfg_in;
   reg_index_type       index;
   logic                write_en;
   logic [SAMPLE_W-1:0] wval;
   logic [SAMPLE_W-1:0] rval;

   assign index    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign write_en = csr_psel && csr_penable && csr_pwrite;
   assign wval     = csr_pwdata[SAMPLE_W-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_FLAP_FALL: cfg_in.flap.fall = wval;
            REG_FLAP_RISE: cfg_in.flap.rise = wval;
            REG_HOME_FALL: cfg_in.home.fall = wval;
            REG_HOME_RISE: cfg_in.home.rise = wval;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_FLAP_FALL: rval = cfg_ff.flap.fall;
         REG_FLAP_RISE: rval = cfg_ff.flap.rise;
         REG_HOME_FALL: rval = cfg_ff.home.fall;
         REG_HOME_RISE: rval = cfg_ff.home.rise;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flap.fall <= DEFAULT_FALL;
         cfg_ff.flap.rise <= DEFAULT_RISE;
         cfg_ff.home.fall <= DEFAULT_FALL;
         cfg_ff.home.rise <= DEFAULT_RISE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_prdata = {{(CSR_DATA_W-SAMPLE_W){1'b0}}, rval};
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

>>> design/sfpc_hyst.sv
// One sensor's hysteresis level with rising-edge detect.
module sfpc_hyst (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic                           primed,
   input  logic [sfpc_pkg::SAMPLE_W-1:0]  sample,
   input  sfpc_pkg::hyst_thr_type         thr,
   output logic                           rise_edge
);
   import sfpc_pkg::*;

   logic level_ff;
   logic level_in;

   always_comb begin
      level_in  = level_ff;
      rise_edge = 1'b0;
      if (!primed) begin
         // first transaction only loads the level
         level_in = (sample >= thr.rise);
      end else if (level_ff && (sample <= thr.fall)) begin
         level_in = 1'b0;
      end else if (!level_ff && (sample >= thr.rise)) begin
         level_in  = 1'b1;
         rise_edge = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 1'b0;
      end else if (step) begin
         level_ff <= level_in;
      end
   end

endmodule

>>> design/split_flap_position_controller.sv
// Top level of the split-flap position controller: state update and result register.
//
// Usage
//   req channel: one transaction per sensor tick, carrying the flap and home
//   ADC samples and the target flap index. rsp channel: one transaction per
//   request, carrying motor drive, position, position-known flag and the
//   home check code. The csr port holds the four hysteresis thresholds; write
//   it only while no request is in flight.
// Latency and throughput
//   A result appears on rsp in the cycle after its request is taken. A new
//   request can be taken every cycle while rsp is not stalled; the whole
//   update is a handful of 12-bit compares plus a position counter step
//   between the request port and the result register.
// Reset
//   Thresholds return to 500 / 1500, levels, position, sync and motor clear.
//   The first request after reset only primes the sensor levels.
// Stall
//   While a result is waiting and rsp_tready is low, req_tready drops; once
//   the result is taken the next request is accepted in the same cycle.
module split_flap_position_controller #(
   parameter int FLAP_COUNT = sfpc_pkg::FLAP_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // tdata: flap_sample[11:0], home_sample[23:12], target_flap[29:24], zero pad
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sfpc_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tdata: motor_on[0], position[6:1], position_known[7], home_check[9:8], zero pad
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sfpc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sfpc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [sfpc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [sfpc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import sfpc_pkg::*;

   localparam int CW = (FLAP_COUNT > 1) ? $clog2(FLAP_COUNT) : 1;
   // common width for comparing the count with the 6-bit target
   localparam int MW = (CW > TARGET_W) ? CW : TARGET_W;
   localparam logic [CW-1:0] LAST_POS = CW'(FLAP_COUNT - 1);

   cfg_type             cfg;
   logic                accept;
   logic [SAMPLE_W-1:0] flap_sample;
   logic [SAMPLE_W-1:0] home_sample;
   logic [TARGET_W-1:0] target_flap;
   logic                flap_rise;
   logic                home_rise;

   // controller state
   logic          primed_ff,  primed_in;
   logic [CW-1:0] count_ff,   count_in;
   logic          sure_ff,    sure_in;
   logic          pending_ff, pending_in;
   logic          motor_ff,   motor_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   check_type        check;
   logic [CW-1:0]    count_step;
   logic             at_target;
   logic [POS_OUT_W-1:0] pos_out;

   sfpc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign flap_sample = req_tdata[SAMPLE_W-1:0];
   assign home_sample = req_tdata[2*SAMPLE_W-1:SAMPLE_W];
   assign target_flap = req_tdata[2*SAMPLE_W+TARGET_W-1:2*SAMPLE_W];

   sfpc_hyst u_flap_hyst (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .primed    (primed_ff),
      .sample    (flap_sample),
      .thr       (cfg.flap),
      .rise_edge (flap_rise)
   );

   sfpc_hyst u_home_hyst (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .primed    (primed_ff),
      .sample    (home_sample),
      .thr       (cfg.home),
      .rise_edge (home_rise)
   );

   // count + 1 modulo the flap count
   assign count_step = (count_ff == LAST_POS) ? '0 : count_ff + CW'(1);

   always_comb begin
      primed_in  = 1'b1;
      count_in   = count_ff;
      sure_in    = sure_ff;
      pending_in = pending_ff;
      motor_in   = motor_ff;
      check      = CHECK_NONE;
      at_target  = 1'b0;
      if (primed_ff) begin
         if (flap_rise) begin
            count_in = count_step;
            if (pending_ff) begin
               // home sync: the advanced count should already have wrapped to 0
               check      = (count_step != '0) ? CHECK_DISAGREE : CHECK_AGREE;
               count_in   = '0;
               sure_in    = 1'b1;
               pending_in = 1'b0;
            end
         end
         // a home edge on the same tick arms the next flap edge
         if (home_rise) begin
            pending_in = 1'b1;
         end
         at_target = (MW'(count_in) == MW'(target_flap));
         if (flap_rise && at_target && sure_in) begin
            motor_in = 1'b0;
         end
         if (!at_target && !motor_in) begin
            motor_in = 1'b1;
         end
      end
   end

   // position output carries the low bits of the count
   assign pos_out = POS_OUT_W'(MW'(count_in));

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[0]             = motor_in;
      rsp_data_in[POS_OUT_W:1]   = pos_out;
      rsp_data_in[POS_OUT_W+1]   = sure_in;
      rsp_data_in[POS_OUT_W+3:POS_OUT_W+2] = check;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff    <= 1'b0;
         count_ff     <= '0;
         sure_ff      <= 1'b0;
         pending_ff   <= 1'b0;
         motor_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            primed_ff  <= primed_in;
            count_ff   <= count_in;
            sure_ff    <= sure_in;
            pending_ff <= pending_in;
            motor_ff   <= motor_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a home check is only reported together with a synced position of 0
   a_check_syncs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff[POS_OUT_W+3:POS_OUT_W+2] != CHECK_NONE)
      |-> (rsp_data_ff[POS_OUT_W:1] == '0) && rsp_data_ff[POS_OUT_W+1])
      else $error("home check reported without sync to position 0");

   // once known, the position stays known until reset
   a_sure_sticky: assert property (@(posedge clock) disable iff (reset)
      sure_ff |=> sure_ff)
      else $error("position_known dropped");

   // the priming transaction changes nothing but the levels
   a_prime_quiet: assert property (@(posedge clock) disable iff (reset)
      accept && !primed_ff |=> (count_ff == '0) && !motor_ff && !pending_ff)
      else $error("priming transaction changed controller state");

   // the count stays inside the flap range
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, count_ff} < (CW+1)'(FLAP_COUNT))
      else $error("position count out of range");

   // a taken result is not dropped before it is delivered
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("pending result lost");

endmodule

>>> tb/tb_split_flap_position_controller.sv
// Self-checking testbench of the split-flap position controller.
`timescale 1ns / 1ps

module tb_split_flap_position_controller;
   import sfpc_pkg::*;

   typedef struct {
      bit                 motor_on;
      bit [POS_OUT_W-1:0] position;
      bit                 position_known;
      check_type          home_check;
   } flap_status_type;

   // Tracks what the controller should report for each accepted tick and
   // matches the rsp transactions against it in order.
   class flap_position_tracker;
      cfg_type         thr;
      bit              flap_lvl;
      bit              home_lvl;
      bit              primed;
      bit              sure;
      bit              home_seen;
      bit              motor;
      int unsigned     count;
      int unsigned     flap_count;
      flap_status_type status_due[$];
      int              errors;

      function new(int unsigned n_flaps);
         flap_count     = n_flaps;
         thr.flap.fall  = DEFAULT_FALL;
         thr.flap.rise  = DEFAULT_RISE;
         thr.home.fall  = DEFAULT_FALL;
         thr.home.rise  = DEFAULT_RISE;
         errors         = 0;
      endfunction

      function void apply_threshold(reg_index_type idx, logic [SAMPLE_W-1:0] v);
         case (idx)
            REG_FLAP_FALL: thr.flap.fall = v;
            REG_FLAP_RISE: thr.flap.rise = v;
            REG_HOME_FALL: thr.home.fall = v;
            REG_HOME_RISE: thr.home.rise = v;
            default: ;
         endcase
      endfunction

      // Hysteresis stage; returns 1 on a rising edge of the level.
      function bit level_step(inout bit lvl, input logic [SAMPLE_W-1:0] s,
                              hyst_thr_type t);
         if (lvl && s <= t.fall) begin
            lvl = 1'b0;
         end else if (!lvl && s >= t.rise) begin
            lvl = 1'b1;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void take_tick(logic [SAMPLE_W-1:0] fs, logic [SAMPLE_W-1:0] hs,
                              logic [TARGET_W-1:0] tgt);
         bit              flap_up;
         bit              home_up;
         check_type       chk;
         flap_status_type st;
         chk = CHECK_NONE;
         if (!primed) begin
            // first tick only loads the levels
            flap_lvl = (fs >= thr.flap.rise);
            home_lvl = (hs >= thr.home.rise);
            primed   = 1'b1;
         end else begin
            flap_up = level_step(flap_lvl, fs, thr.flap);
            home_up = level_step(home_lvl, hs, thr.home);
            if (flap_up) begin
               count = (count + 1) % flap_count;
               if (home_seen) begin
                  chk       = (count != 0) ? CHECK_DISAGREE : CHECK_AGREE;
                  count     = 0;
                  sure      = 1'b1;
                  home_seen = 1'b0;
               end
            end
            // home edge lands after the flap edge of the same tick
            if (home_up) home_seen = 1'b1;
            if (flap_up && count == tgt && sure) motor = 1'b0;
            if (count != tgt && !motor) motor = 1'b1;
         end
         st.motor_on       = motor;
         st.position       = count[POS_OUT_W-1:0];
         st.position_known = sure;
         st.home_check     = chk;
         status_due.push_back(st);
      endfunction

      function void match_status(logic [RSP_DATA_W-1:0] d);
         flap_status_type st;
         if (status_due.size() == 0) begin
            $error("rsp transaction with no tick outstanding: tdata 0x%0h", d);
            errors++;
            return;
         end
         st = status_due.pop_front();
         if (d[0] !== st.motor_on) begin
            $error("motor_on: expected %0d, got %0d", st.motor_on, d[0]);
            errors++;
         end
         if (d[6:1] !== st.position) begin
            $error("position: expected %0d, got %0d", st.position, d[6:1]);
            errors++;
         end
         if (d[7] !== st.position_known) begin
            $error("position_known: expected %0d, got %0d", st.position_known, d[7]);
            errors++;
         end
         if (d[9:8] !== st.home_check) begin
            $error("home_check: expected %0d, got %0d", st.home_check, d[9:8]);
            errors++;
         end
         if (d[RSP_DATA_W-1:10] !== '0) begin
            $error("pad: expected 0, got 0x%0h", d[RSP_DATA_W-1:10]);
            errors++;
         end
      endfunction

      function int outstanding();
         return status_due.size();
      endfunction
   endclass

   localparam int N_FLAPS     = FLAP_COUNT_DEF;
   localparam int PHASES      = 6;
   localparam int PHASE_TICKS = 250;
   localparam int HOLD_CYCLES = 400;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   flap_position_tracker tracker;
   int                   csr_errors = 0;

   // Shared between the sender and the receiver process.
   bit idle_on      = 1'b1;
   bit hold_request = 1'b0;
   int hold_left    = 0;

   // Sensor waveform generator state.
   bit                  flap_hi     = 1'b0;
   int                  ticks_left  = 0;
   int                  sync_edges  = 0;
   int                  home_period = 4;
   bit                  home_armed  = 1'b0;
   logic [TARGET_W-1:0] tgt_hold    = '0;

   split_flap_position_controller #(.FLAP_COUNT(N_FLAPS)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit: far beyond the slowest legal run (gaps, stalls, hold-off).
   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

   // Receiver: random back-pressure, a quiet stretch, and one long hold-off
   // counted here so the block fills up and drops req_tready.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on) begin
            rsp_tready <= ($urandom_range(0, 99) >= 35);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Values at the edge are read right after it, before any update lands.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.match_status(rsp_tdata);
   end

   // Sample for a wanted level; a tenth fall inside the hysteresis band.
   function automatic logic [SAMPLE_W-1:0] level_sample(bit hi, hyst_thr_type t);
      if ($urandom_range(0, 99) < 10) return SAMPLE_W'($urandom_range(t.fall, t.rise));
      if (hi) return SAMPLE_W'($urandom_range(t.rise, 4095));
      return SAMPLE_W'($urandom_range(0, t.fall));
   endfunction

   // Mostly a clean flap pulse train with a home pulse once per revolution
   // (often exactly one revolution, else a short or long one); the rest is
   // raw noise on all fields.
   task automatic make_tick(output logic [SAMPLE_W-1:0] fs, output logic [SAMPLE_W-1:0] hs,
                            output logic [TARGET_W-1:0] tgt);
      if ($urandom_range(0, 99) < 15) begin
         fs  = SAMPLE_W'($urandom_range(0, 4095));
         hs  = SAMPLE_W'($urandom_range(0, 4095));
         tgt = TARGET_W'($urandom_range(0, 63));
      end else begin
         if ($urandom_range(0, 79) == 0) tgt_hold = TARGET_W'($urandom_range(0, 63));
         if (ticks_left == 0) begin
            flap_hi    = !flap_hi;
            ticks_left = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
            if (flap_hi && home_armed) begin
               // this flap edge should take the home sync
               home_armed  = 1'b0;
               sync_edges  = 0;
               home_period = $urandom_range(0, 1) ? N_FLAPS : $urandom_range(1, N_FLAPS + 6);
            end else if (flap_hi) begin
               sync_edges++;
            end
         end
         ticks_left--;
         if (!flap_hi && sync_edges >= home_period - 1) home_armed = 1'b1;
         fs  = level_sample(flap_hi, tracker.thr.flap);
         hs  = level_sample(home_armed && !flap_hi, tracker.thr.home);
         tgt = tgt_hold;
      end
   endtask

   // One req transaction, with random gaps ahead of it.
   task automatic send_tick(logic [SAMPLE_W-1:0] fs, logic [SAMPLE_W-1:0] hs,
                            logic [TARGET_W-1:0] tgt);
      if (idle_on) begin
         while ($urandom_range(0, 99) < 35) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, tgt, hs, fs};
      do @(posedge clock); while (!req_tready);
      tracker.take_tick(fs, hs, tgt);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // APB write followed by a read-back of the same register; psel stays
   // high across the two so no signal is assigned twice in one step.
   task automatic csr_write_checked(reg_index_type idx, logic [SAMPLE_W-1:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(int'(idx) * 4);
      csr_pwdata  <= CSR_DATA_W'(v);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.apply_threshold(idx, v);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(v)) begin
         $error("prdata of %s: expected %0d, got %0d", idx.name(), v, csr_prdata);
         csr_errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_thresholds(cfg_type c);
      csr_write_checked(REG_FLAP_FALL, c.flap.fall);
      csr_write_checked(REG_FLAP_RISE, c.flap.rise);
      csr_write_checked(REG_HOME_FALL, c.home.fall);
      csr_write_checked(REG_HOME_RISE, c.home.rise);
   endtask

   // Directed ticks at reset thresholds 500 / 1500: priming, exact threshold
   // hits, a home edge ahead of a flap edge, both edges in one tick, and
   // targets at both ends.
   localparam int N_DIRECTED = 16;
   logic [SAMPLE_W-1:0] dir_fs  [N_DIRECTED] = '{4095,    0, 4095,  500, 1500,  501,    0, 1499,
                                                 4095,    0, 4095,    0, 4095,    0, 4095, 2000};
   logic [SAMPLE_W-1:0] dir_hs  [N_DIRECTED] = '{   0, 4095, 4095,  500, 1500, 1499,    0,    0,
                                                    0,    0,    0,    0, 4095,    0,    0,    0};
   logic [TARGET_W-1:0] dir_tgt [N_DIRECTED] = '{  63,    0,    0,    1,    1,    1,    2,    2,
                                                    2,   63,   63,    2,    2,   63,    1,   63};

   initial begin
      logic [SAMPLE_W-1:0] fs;
      logic [SAMPLE_W-1:0] hs;
      logic [TARGET_W-1:0] tgt;
      cfg_type             c;

      tracker     = new(N_FLAPS);
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_DIRECTED; i++) send_tick(dir_fs[i], dir_hs[i], dir_tgt[i]);

      for (int p = 0; p < PHASES; p++) begin
         // phase 0 keeps the reset thresholds
         if (p > 0) begin
            case (p)
               1: c = '{flap: '{fall: 1000, rise: 3000}, home: '{fall: 200, rise: 800}};
               2: c = '{flap: '{fall: 0, rise: 4095}, home: '{fall: 4095, rise: 0}};
               3: c = '{flap: '{fall: 3000, rise: 1000}, home: '{fall: 2500, rise: 700}};
               4: c = '{flap: '{fall: 0, rise: 0}, home: '{fall: 4095, rise: 4095}};
               default: begin
                  c.flap.fall = SAMPLE_W'($urandom_range(0, 2000));
                  c.flap.rise = SAMPLE_W'($urandom_range(2000, 4095));
                  c.home.fall = SAMPLE_W'($urandom_range(0, 4095));
                  c.home.rise = SAMPLE_W'($urandom_range(0, 4095));
               end
            endcase
            drain();
            load_thresholds(c);
         end
         for (int n = 0; n < PHASE_TICKS; n++) begin
            // a stretch with no idling on either side
            idle_on = !(p == 2 && n >= 40 && n < 200);
            if (p == 1 && n == 60) hold_request = 1'b1;
            make_tick(fs, hs, tgt);
            send_tick(fs, hs, tgt);
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (tracker.errors == 0 && csr_errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> split_flap_position_controller.f
design/sfpc_pkg.sv
design/sfpc_csr.sv
design/sfpc_hyst.sv
design/split_flap_position_controller.sv
tb/tb_split_flap_position_controller.sv
